### src/running_time_hour_meter_unit_defines.svh
// Assertion macros for the running time hour meter.
// Used by the top level only; empty bodies when SYNTHESIS is defined.
`ifndef RUNNING_TIME_HOUR_METER_UNIT_DEFINES_SVH
`define RUNNING_TIME_HOUR_METER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define HRM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HRM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HRM_ASSERT(label, clk, rst, prop, msg)
`define HRM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### src/hrm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the running time hour meter.
// No dependencies; used by every other source file but the defines header.
package hrm_pkg;

  localparam int CNT_W    = 32;
  localparam int STEP_W   = 16;
  localparam int KIND_W   = 3;
  localparam int SUB_W    = 10;
  localparam int QUO_W    = 7;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [SUB_W-1:0] MS_PER_S = SUB_W'(1000);

  localparam logic [KIND_W-1:0] KIND_SAMPLE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RESTORE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TRIP    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FLUSH   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OUTCOME = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STORE_INTERVAL = 4'd1;

  localparam logic [STEP_W-1:0] MAX_STEP_RESET       = 16'd2000;
  localparam logic [STEP_W-1:0] STORE_INTERVAL_RESET = 16'd60;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CREDIT,
    OP_RESTORE,
    OP_TRIP,
    OP_FLUSH,
    OP_OUTCOME
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [QUO_W-1:0] quo;
    logic [SUB_W-1:0] rem;
    logic             store_ok;
    logic [CNT_W-1:0] restored_total;
    logic [CNT_W-1:0] restored_trip;
  } cmd_t;

  typedef struct packed {
    logic             store_request;
    logic [CNT_W-1:0] total_seconds;
    logic [CNT_W-1:0] trip_seconds;
    logic             unsaved;
  } res_t;

endpackage

### src/hrm_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the hour meter: input items, results, register writes.
// Depends on hrm_pkg for field widths.
interface hrm_item_if;
  logic                       valid;
  logic                       ready;
  logic [hrm_pkg::KIND_W-1:0] kind;
  logic                       engine_turning;
  logic [hrm_pkg::CNT_W-1:0]  now_ms;
  logic [hrm_pkg::CNT_W-1:0]  restored_total;
  logic [hrm_pkg::CNT_W-1:0]  restored_trip;
  logic                       store_ok;

  modport source(output valid, kind, engine_turning, now_ms, restored_total, restored_trip,
                 store_ok, input ready);
  modport sink(input valid, kind, engine_turning, now_ms, restored_total, restored_trip,
               store_ok, output ready);
endinterface

interface hrm_result_if;
  logic                      valid;
  logic                      ready;
  logic                      store_request;
  logic [hrm_pkg::CNT_W-1:0] total_seconds;
  logic [hrm_pkg::CNT_W-1:0] trip_seconds;
  logic                      unsaved;

  modport source(output valid, store_request, total_seconds, trip_seconds, unsaved,
                 input ready);
  modport sink(input valid, store_request, total_seconds, trip_seconds, unsaved,
               output ready);
endinterface

interface hrm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hrm_pkg::CFG_IDX_W-1:0]  index;
  logic [hrm_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### src/hrm_fifo.sv
`timescale 1ns / 1ps
// Command queue between the front and the back of the hour meter.
// Depends on hrm_pkg for the command type.
module hrm_fifo #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hrm_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output hrm_pkg::cmd_t dout,
  output logic          not_empty
);
  import hrm_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign dout      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/hrm_front.sv
`timescale 1ns / 1ps
// Front of the hour meter: accepts items, tracks the sample clock latch,
// checks the interval and splits it into seconds and milliseconds. Uses hrm_pkg.
module hrm_front (
  input  logic                         clk,
  input  logic                         rst,
  hrm_item_if.sink                     item,
  input  logic [hrm_pkg::STEP_W-1:0]   max_step,
  output logic                         push,
  output hrm_pkg::cmd_t                cmd,
  input  logic                         full
);
  import hrm_pkg::*;

  localparam logic [13:0] RECIP_125 = 14'd8389;
  localparam int          RECIP_SH  = 20;

  logic             clock_latched;
  logic [CNT_W-1:0] last_ms;

  logic              s1_valid;
  logic [KIND_W-1:0] s1_kind;
  logic              s1_credit_en;
  logic [CNT_W-1:0]  s1_dt;
  logic              s1_ok;
  logic [CNT_W-1:0]  s1_total;
  logic [CNT_W-1:0]  s1_trip;

  logic s2_valid;
  logic s1_adv;
  logic s2_adv;
  logic accept;
  logic dt_fits;

  logic [26:0]       prod;
  logic [STEP_W-1:0] quo_ms;
  logic [STEP_W-1:0] rem;
  logic [QUO_W-1:0]  quo;
  cmd_t              cmd_next;

  assign s2_adv     = s2_valid && !full;
  assign s1_adv     = s1_valid && (!s2_valid || s2_adv);
  assign item.ready = !s1_valid || s1_adv;
  assign accept     = item.valid && item.ready;
  assign push       = s2_adv;

  assign dt_fits = (s1_dt[CNT_W-1:STEP_W] == '0) && (s1_dt[STEP_W-1:0] <= max_step);

  // divide by 1000 as (dt >> 3) / 125 through a reciprocal product
  assign prod   = {14'd0, s1_dt[STEP_W-1:3]} * {13'd0, RECIP_125};
  assign quo    = prod[RECIP_SH+QUO_W-1:RECIP_SH];
  assign quo_ms = {{(STEP_W-QUO_W){1'b0}}, quo} * {{(STEP_W-SUB_W){1'b0}}, MS_PER_S};
  assign rem    = s1_dt[STEP_W-1:0] - quo_ms;

  always_comb begin
    cmd_next.quo            = quo;
    cmd_next.rem            = rem[SUB_W-1:0];
    cmd_next.store_ok       = s1_ok;
    cmd_next.restored_total = s1_total;
    cmd_next.restored_trip  = s1_trip;
    unique case (s1_kind)
      KIND_SAMPLE:  cmd_next.op = (s1_credit_en && dt_fits) ? OP_CREDIT : OP_NOP;
      KIND_RESTORE: cmd_next.op = OP_RESTORE;
      KIND_TRIP:    cmd_next.op = OP_TRIP;
      KIND_FLUSH:   cmd_next.op = OP_FLUSH;
      KIND_OUTCOME: cmd_next.op = OP_OUTCOME;
      default:      cmd_next.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind      <= item.kind;
      s1_credit_en <= clock_latched && item.engine_turning;
      s1_dt        <= item.now_ms - last_ms;
      s1_ok        <= item.store_ok;
      s1_total     <= item.restored_total;
      s1_trip      <= item.restored_trip;
    end
    if (s1_adv) begin
      cmd <= cmd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_latched <= 1'b0;
      last_ms       <= '0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
    end else begin
      if (accept && item.kind == KIND_SAMPLE) begin
        clock_latched <= 1'b1;
        last_ms       <= item.now_ms;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
    end
  end

endmodule

### src/hrm_back.sv
`timescale 1ns / 1ps
// Back of the hour meter: carries commands into the counters, raises store
// requests and holds the result register. Uses hrm_pkg.
module hrm_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  hrm_pkg::cmd_t              cmd,
  output logic                       pop,
  input  logic [hrm_pkg::STEP_W-1:0] store_interval,
  output logic                       res_valid,
  input  logic                       res_ready,
  output hrm_pkg::res_t              res
);
  import hrm_pkg::*;

  logic [SUB_W-1:0] sub_ms;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] trip;
  logic [CNT_W-1:0] mark;
  logic             dirty;

  logic [SUB_W:0]   sub_sum;
  logic             carry;
  logic [QUO_W-1:0] whole;
  logic [CNT_W:0]   total_sum;
  logic [CNT_W:0]   trip_sum;
  logic [CNT_W-1:0] total_sat;
  logic [CNT_W-1:0] trip_sat;
  logic             due;

  logic [SUB_W-1:0] sub_ms_next;
  logic [CNT_W-1:0] total_next;
  logic [CNT_W-1:0] trip_next;
  logic [CNT_W-1:0] mark_next;
  logic             dirty_next;
  logic             req;

  assign pop = cmd_valid && (!res_valid || res_ready);

  assign sub_sum   = {1'b0, sub_ms} + {1'b0, cmd.rem};
  assign carry     = sub_sum >= {1'b0, MS_PER_S};
  assign whole     = cmd.quo + QUO_W'(carry);
  assign total_sum = {1'b0, total} + (CNT_W+1)'(whole);
  assign trip_sum  = {1'b0, trip} + (CNT_W+1)'(whole);
  assign total_sat = total_sum[CNT_W] ? '1 : total_sum[CNT_W-1:0];
  assign trip_sat  = trip_sum[CNT_W] ? '1 : trip_sum[CNT_W-1:0];
  assign due       = (total_sat - mark) >= {{(CNT_W-STEP_W){1'b0}}, store_interval};

  always_comb begin
    sub_ms_next = sub_ms;
    total_next  = total;
    trip_next   = trip;
    mark_next   = mark;
    dirty_next  = dirty;
    req         = 1'b0;
    unique case (cmd.op)
      OP_CREDIT: begin
        sub_ms_next = carry ? SUB_W'(sub_sum - {1'b0, MS_PER_S}) : sub_sum[SUB_W-1:0];
        if (whole != '0) begin
          total_next = total_sat;
          trip_next  = trip_sat;
          dirty_next = 1'b1;
          if (due) begin
            req       = 1'b1;
            mark_next = total_sat;
          end
        end
      end
      OP_RESTORE: begin
        total_next = cmd.restored_total;
        trip_next  = cmd.restored_trip;
        mark_next  = cmd.restored_total;
        dirty_next = 1'b0;
      end
      OP_TRIP: begin
        trip_next  = '0;
        dirty_next = 1'b1;
        req        = 1'b1;
        mark_next  = total;
      end
      OP_FLUSH: begin
        if (dirty) begin
          req       = 1'b1;
          mark_next = total;
        end
      end
      OP_OUTCOME: begin
        if (cmd.store_ok) begin
          dirty_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.store_request <= req;
      res.total_seconds <= total_next;
      res.trip_seconds  <= trip_next;
      res.unsaved       <= dirty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_ms    <= '0;
      total     <= '0;
      trip      <= '0;
      mark      <= '0;
      dirty     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        sub_ms    <= sub_ms_next;
        total     <= total_next;
        trip      <= trip_next;
        mark      <= mark_next;
        dirty     <= dirty_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

### src/running_time_hour_meter_unit.sv
`timescale 1ns / 1ps
// Running time hour meter. An item goes through s1, s2, the queue and the result register.
// Throughput: one item per cycle when not stalled; a pop updates remainder, counters and mark.
// The front holds two pipeline stages, the queue QUEUE_DEPTH commands, the back one result.
// Reset: synchronous rst clears counters, latch, mark, dirty flag and registers to defaults.
// Depends on hrm_pkg, the channel interfaces, hrm_front, hrm_fifo and hrm_back.
`include "running_time_hour_meter_unit_defines.svh"
module running_time_hour_meter_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  hrm_item_if.sink      item,
  hrm_result_if.source  result,
  hrm_cfg_if.sink       cfg
);
  import hrm_pkg::*;

  logic [STEP_W-1:0] max_step;
  logic [STEP_W-1:0] store_interval;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_in;
  cmd_t q_out;
  res_t res;
  logic req_shown;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_step       <= MAX_STEP_RESET;
      store_interval <= STORE_INTERVAL_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_MAX_STEP) begin
        max_step <= cfg.data;
      end
      if (cfg.index == CFG_STORE_INTERVAL) begin
        store_interval <= cfg.data;
      end
    end
  end

  hrm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .max_step (max_step),
    .push     (q_push),
    .cmd      (q_in),
    .full     (q_full)
  );

  hrm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .din       (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .dout      (q_out),
    .not_empty (q_valid)
  );

  hrm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (q_valid),
    .cmd            (q_out),
    .pop            (q_pop),
    .store_interval (store_interval),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res            (res)
  );

  assign result.store_request = res.store_request;
  assign result.total_seconds = res.total_seconds;
  assign result.trip_seconds  = res.trip_seconds;
  assign result.unsaved       = res.unsaved;

  assign req_shown = result.valid && result.store_request;

  `HRM_ASSERT(a_queue_no_overflow, clk, rst, !(q_push && q_full), "queue overflow")
  `HRM_ASSERT(a_pop_needs_data, clk, rst, q_pop |-> q_valid, "pop from empty queue")
  `HRM_ASSERT(a_request_is_unsaved, clk, rst, req_shown |-> res.unsaved, "request while clean")
  `HRM_ASSERT_ALWAYS(a_reset_clears_result, clk, rst |=> !result.valid, "result valid after reset")

endmodule

### bench/running_time_hour_meter_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the running time hour meter: a directed table, then random phases
// under several register settings. Depends on hrm_pkg, the channel interfaces and the top level.
module running_time_hour_meter_unit_tb;
  import hrm_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              turning;
    logic [CNT_W-1:0]  now_ms;
    logic [CNT_W-1:0]  restored_total;
    logic [CNT_W-1:0]  restored_trip;
    logic              store_ok;
  } meter_req_t;

  typedef struct packed {
    meter_req_t req;
    logic       typed;
    res_t       reading;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  hrm_item_if   item_ch();
  hrm_result_if result_ch();
  hrm_cfg_if    cfg_ch();

  running_time_hour_meter_unit DUT (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  always #5 clk = ~clk;

  logic              latched;
  logic [CNT_W-1:0]  last_ms;
  logic [16:0]       sub_ms;
  logic [CNT_W-1:0]  total_s;
  logic [CNT_W-1:0]  trip_s;
  logic [CNT_W-1:0]  mark_s;
  logic              dirty;
  logic [STEP_W-1:0] max_step;
  logic [STEP_W-1:0] interval_s;

  res_t             due_readings[$];
  res_t             want;
  plan_row_t        plan[$];
  int               bad_count = 0;
  int               src_idle_pct = 37;
  int               sink_idle_pct = 37;
  int               sink_hold = 0;
  logic [CNT_W-1:0] clock_ms = '0;

  function automatic logic [CNT_W-1:0] clamp_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [CNT_W:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    return wide[CNT_W] ? {CNT_W{1'b1}} : wide[CNT_W-1:0];
  endfunction

  function automatic res_t advance_meter(input meter_req_t r);
    logic [CNT_W-1:0] dt;
    logic [CNT_W-1:0] whole;
    logic             req;
    res_t             out;
    req = 1'b0;
    case (r.kind)
      KIND_SAMPLE: begin
        if (!latched) begin
          latched = 1'b1;
          last_ms = r.now_ms;
        end else begin
          dt = r.now_ms - last_ms;
          last_ms = r.now_ms;
          if (r.turning && dt <= {16'd0, max_step}) begin
            sub_ms = sub_ms + dt[16:0];
            if (sub_ms >= 17'd1000) begin
              whole = CNT_W'(sub_ms / 17'd1000);
              total_s = clamp_add(total_s, whole);
              trip_s = clamp_add(trip_s, whole);
              sub_ms = sub_ms % 17'd1000;
              dirty = 1'b1;
              if (total_s - mark_s >= {16'd0, interval_s}) begin
                req = 1'b1;
                mark_s = total_s;
              end
            end
          end
        end
      end
      KIND_RESTORE: begin
        total_s = r.restored_total;
        trip_s = r.restored_trip;
        mark_s = r.restored_total;
        dirty = 1'b0;
      end
      KIND_TRIP: begin
        trip_s = '0;
        dirty = 1'b1;
        req = 1'b1;
        mark_s = total_s;
      end
      KIND_FLUSH: begin
        if (dirty) begin
          req = 1'b1;
          mark_s = total_s;
        end
      end
      KIND_OUTCOME: begin
        if (r.store_ok)
          dirty = 1'b0;
      end
      default: ;
    endcase
    out.store_request = req;
    out.total_seconds = total_s;
    out.trip_seconds = trip_s;
    out.unsaved = dirty;
    return out;
  endfunction

  function automatic plan_row_t plan_row(input logic [KIND_W-1:0] kind, input logic turning,
                                         input logic [CNT_W-1:0] now_ms,
                                         input logic [CNT_W-1:0] r_total,
                                         input logic [CNT_W-1:0] r_trip, input logic ok,
                                         input logic typed, input logic e_req,
                                         input logic [CNT_W-1:0] e_total,
                                         input logic [CNT_W-1:0] e_trip, input logic e_unsaved);
    plan_row_t row;
    row.req = '{kind, turning, now_ms, r_total, r_trip, ok};
    row.typed = typed;
    row.reading = '{e_req, e_total, e_trip, e_unsaved};
    return row;
  endfunction

  function automatic meter_req_t draw_request();
    meter_req_t       r;
    int               pick;
    logic [CNT_W-1:0] dt;
    r.kind = KIND_SAMPLE;
    r.turning = ($urandom_range(99) < 85);
    r.now_ms = $urandom;
    r.restored_total = $urandom;
    r.restored_trip = $urandom;
    r.store_ok = ($urandom_range(99) < 70);
    pick = $urandom_range(99);
    if (pick < 75) begin
      pick = $urandom_range(99);
      if (pick < 80)
        dt = $urandom_range(max_step);
      else if (pick < 90)
        dt = {16'd0, max_step};
      else if (pick < 96)
        dt = {16'd0, max_step} + 1;
      else
        dt = $urandom;
      clock_ms = clock_ms + dt;
      r.now_ms = clock_ms;
    end else if (pick < 81) begin
      r.kind = KIND_OUTCOME;
    end else if (pick < 86) begin
      r.kind = KIND_FLUSH;
    end else if (pick < 89) begin
      r.kind = KIND_TRIP;
    end else if (pick < 92) begin
      r.kind = KIND_RESTORE;
      pick = $urandom_range(3);
      if (pick == 0) begin
        r.restored_total = {CNT_W{1'b1}} - $urandom_range(120);
        r.restored_trip = {CNT_W{1'b1}} - $urandom_range(120);
      end else if (pick == 1) begin
        r.restored_total = $urandom_range(1000);
        r.restored_trip = $urandom_range(1000);
      end
    end else if (pick < 95) begin
      r.kind = KIND_W'($urandom_range((1 << KIND_W) - 1, KIND_OUTCOME + 1));
    end else begin
      clock_ms = r.now_ms;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got_v,
                                 input logic [CNT_W-1:0] want_v);
    if (bad_count < 200)
      $display("%0t ERROR hour meter %s: got %0h, want %0h", $time, what, got_v, want_v);
    bad_count++;
  endtask

  task automatic send(input meter_req_t r, input res_t typed_reading, input logic typed);
    res_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.kind <= r.kind;
    item_ch.engine_turning <= r.turning;
    item_ch.now_ms <= r.now_ms;
    item_ch.restored_total <= r.restored_total;
    item_ch.restored_trip <= r.restored_trip;
    item_ch.store_ok <= r.store_ok;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    predicted = advance_meter(r);
    due_readings.push_back(typed ? typed_reading : predicted);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (due_readings.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_MAX_STEP:       max_step = value;
      CFG_STORE_INTERVAL: interval_s = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Receiver: random stalls, or a long hold-off while sink_hold counts down.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        sink_hold = sink_hold - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (due_readings.size() == 0) begin
        report_mismatch("result with nothing pending", result_ch.total_seconds, '0);
      end else begin
        want = due_readings.pop_front();
        if (result_ch.store_request !== want.store_request)
          report_mismatch("store_request", result_ch.store_request, want.store_request);
        if (result_ch.total_seconds !== want.total_seconds)
          report_mismatch("total_seconds", result_ch.total_seconds, want.total_seconds);
        if (result_ch.trip_seconds !== want.trip_seconds)
          report_mismatch("trip_seconds", result_ch.trip_seconds, want.trip_seconds);
        if (result_ch.unsaved !== want.unsaved)
          report_mismatch("unsaved", result_ch.unsaved, want.unsaved);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("running_time_hour_meter_unit: mismatch");
    $finish;
  end

  initial begin
    int phase_len[5] = '{250, 100, 200, 250, 200};
    int mx;
    int iv;
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.kind <= KIND_SAMPLE;
    item_ch.engine_turning <= 1'b0;
    item_ch.now_ms <= '0;
    item_ch.restored_total <= '0;
    item_ch.restored_trip <= '0;
    item_ch.store_ok <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_MAX_STEP;
    cfg_ch.data <= '0;
    latched = 1'b0;
    last_ms = '0;
    sub_ms = '0;
    total_s = '0;
    trip_s = '0;
    mark_s = '0;
    dirty = 1'b0;
    max_step = MAX_STEP_RESET;
    interval_s = STORE_INTERVAL_RESET;

    plan.push_back(plan_row(KIND_FLUSH, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    plan.push_back(plan_row(KIND_OUTCOME, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    plan.push_back(plan_row(KIND_SAMPLE, 1, 32'hFFFF_FC18, 0, 0, 0, 1, 0, 0, 0, 0));
    plan.push_back(plan_row(KIND_SAMPLE, 1, 0, 0, 0, 0, 1, 0, 1, 1, 1));
    plan.push_back(plan_row(KIND_SAMPLE, 1, 2001, 0, 0, 0, 1, 0, 1, 1, 1));
    plan.push_back(plan_row(KIND_SAMPLE, 0, 4001, 0, 0, 0, 1, 0, 1, 1, 1));
    plan.push_back(plan_row(KIND_SAMPLE, 1, 6001, 0, 0, 0, 1, 0, 3, 3, 1));
    plan.push_back(plan_row(KIND_SAMPLE, 1, 6500, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(plan_row(KIND_TRIP, 0, 0, 0, 0, 0, 1, 1, 3, 0, 1));
    plan.push_back(plan_row(KIND_OUTCOME, 0, 0, 0, 0, 1, 1, 0, 3, 0, 0));
    plan.push_back(plan_row(KIND_SAMPLE, 1, 7001, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(plan_row(KIND_OUTCOME, 0, 0, 0, 0, 1, 1, 0, 4, 1, 0));
    plan.push_back(plan_row(KIND_RESTORE, 0, 0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 0,
                            1, 0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 0));
    plan.push_back(plan_row(KIND_SAMPLE, 1, 9001, 0, 0, 0,
                            1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    plan.push_back(plan_row(KIND_FLUSH, 0, 0, 0, 0, 0, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    plan.push_back(plan_row(KIND_OUTCOME, 0, 0, 0, 0, 0,
                            1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    plan.push_back(plan_row(KIND_OUTCOME + 3'd1, 1, 32'hFFFF_FFFF, 0, 0, 1,
                            1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    plan.push_back(plan_row(KIND_OUTCOME + 3'd2, 1, 0, 0, 0, 1,
                            1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    plan.push_back(plan_row(KIND_OUTCOME + 3'd3, 1, 0, 0, 0, 1,
                            1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    plan.push_back(plan_row(KIND_RESTORE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    plan.push_back(plan_row(KIND_SAMPLE, 1, 32'hFFFF_FFFF, 0, 0, 0, 1, 0, 0, 0, 0));
    plan.push_back(plan_row(KIND_SAMPLE, 1, 1000, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(plan_row(KIND_TRIP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[k])
      send(plan[k].req, plan[k].reading, plan[k].typed);
    clock_ms = 1000;

    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: begin mx = 2000;  iv = 60;    end
        1: begin mx = 0;     iv = 1;     end
        2: begin mx = 65535; iv = 65535; end
        3: begin mx = 1000;  iv = 1;     end
        default: begin
          mx = $urandom_range(65535);
          iv = $urandom_range(1, 200);
        end
      endcase
      write_reg(CFG_MAX_STEP, CFG_DATA_W'(mx));
      write_reg(CFG_STORE_INTERVAL, CFG_DATA_W'(iv));
      src_idle_pct = (p == 3) ? 0 : 37;
      sink_idle_pct = (p == 3) ? 0 : 37;
      for (int i = 0; i < phase_len[p]; i++) begin
        // fill the pipeline against a stalled receiver
        if (p == 0 && i == 0) begin
          sink_hold = 100;
          src_idle_pct = 0;
        end
        if (p == 0 && i == 40)
          src_idle_pct = 37;
        if (p == 2 && i == 100)
          drain();
        send(draw_request(), '0, 1'b0);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (bad_count == 0)
      $display("running_time_hour_meter_unit: match");
    else
      $display("running_time_hour_meter_unit: mismatch");
    $finish;
  end

endmodule

### running_time_hour_meter_unit.f
+incdir+src
src/hrm_pkg.sv
src/hrm_if.sv
src/hrm_fifo.sv
src/hrm_front.sv
src/hrm_back.sv
src/running_time_hour_meter_unit.sv
bench/running_time_hour_meter_unit_tb.sv
